// File: rtl/reader_writer_lock_arbiter_assert.svh
// Assertion macros used by the checker file of the lock arbiter.
`ifndef READER_WRITER_LOCK_ARBITER_ASSERT_SVH
`define READER_WRITER_LOCK_ARBITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWL_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lock arbiter check failed");

// The consequent must hold in the cycle after the antecedent.
`define RWL_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lock arbiter check failed");

`endif

// File: rtl/rwl_pkg.sv
`default_nettype none
package rwl_pkg;

	localparam int unsigned MAX_REQUESTERS_DEF = 16;

	localparam int unsigned ACT_W       = 4;
	localparam int unsigned REQ_W       = 4;
	localparam int unsigned STATUS_W    = 3;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned POLICY_W    = 3;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned PADDR_W     = 5;
	localparam int unsigned PDATA_W     = 32;
	localparam int unsigned REG_IDX_W   = 3;

	localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

	localparam logic [ACT_W-1:0] ACT_READ_ACQ  = 4'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE_ACQ = 4'd1;
	localparam logic [ACT_W-1:0] ACT_EXCL_ACQ  = 4'd2;
	localparam logic [ACT_W-1:0] ACT_READ_REL  = 4'd3;
	localparam logic [ACT_W-1:0] ACT_WRITE_REL = 4'd4;
	localparam logic [ACT_W-1:0] ACT_EXCL_REL  = 4'd5;
	localparam logic [ACT_W-1:0] ACT_ANN_READ  = 4'd6;
	localparam logic [ACT_W-1:0] ACT_ANN_EXCL  = 4'd7;
	localparam logic [ACT_W-1:0] ACT_REGISTER  = 4'd8;
	localparam logic [ACT_W-1:0] ACT_UNREG     = 4'd9;

	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_REFUSED   = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_HOLDING   = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

	localparam logic [POLICY_W-1:0] POL_EXCL   = 3'd0;
	localparam logic [POLICY_W-1:0] POL_NONE   = 3'd1;
	localparam logic [POLICY_W-1:0] POL_RR     = 3'd2;
	localparam logic [POLICY_W-1:0] POL_READER = 3'd3;
	localparam logic [POLICY_W-1:0] POL_WRITER = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_POLICY   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT_ON = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RD_BLK   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WR_BLK   = 3'd4;

	localparam logic [CNT_W-1:0] LIMIT_RST = 5'd16;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SORT = 3'b100
	} fsm_t;

	typedef struct packed {
		logic wr;
		logic drop;
		logic take_lo;
		logic take_hi;
	} cell_ctl_t;

	typedef struct packed {
		logic reg_wr;
		logic drop;
		logic sort_on;
		logic sort_phase;
	} turn_ctl_t;

	typedef struct packed {
		logic hit;
		logic next_valid;
		logic full;
	} turn_sts_t;

endpackage
`default_nettype wire

// File: rtl/rwl_cell.sv
`default_nettype none
module rwl_cell import rwl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [REQ_W-1:0] who,
	input  logic [REQ_W-1:0] lo_data,
	input  logic             lo_valid,
	input  logic [REQ_W-1:0] hi_data,
	input  logic             hi_valid,
	output logic [REQ_W-1:0] data,
	output logic             valid
);

	logic [REQ_W-1:0] data_q;
	logic             valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			data_q <= who;
		end else if (ctl.take_hi) begin
			data_q <= hi_data;
		end else if (ctl.take_lo) begin
			data_q <= lo_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.wr) begin
			valid_q <= 1'b1;
		end else if (ctl.drop && valid_q && (data_q == who)) begin
			valid_q <= 1'b0;
		end else if (ctl.take_hi) begin
			valid_q <= hi_valid;
		end else if (ctl.take_lo) begin
			valid_q <= lo_valid;
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule
`default_nettype wire

// File: rtl/rwl_turn_chain.sv
`default_nettype none
module rwl_turn_chain import rwl_pkg::*; #(
	parameter int unsigned DEPTH = MAX_REQUESTERS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  turn_ctl_t                ctl,
	input  logic [REQ_W-1:0]         who,
	input  logic [$clog2(DEPTH)-1:0] turn_index,
	output turn_sts_t                sts
);

	localparam int unsigned IDX_W = $clog2(DEPTH);

	logic [REQ_W-1:0] data [DEPTH];
	logic [DEPTH-1:0] valid;
	logic [DEPTH-2:0] swap;
	logic [DEPTH-1:0] hit_v;
	logic [DEPTH-1:0] nxt_v;

	// Odd-even transposition on the valid bits: a free cell swaps with a used
	// right neighbor, so used entries move left and keep their order.
	for (genvar b = 0; b < DEPTH - 1; b++) begin : g_swap
		assign swap[b] = ctl.sort_on && (ctl.sort_phase == 1'(b % 2))
			&& !valid[b] && valid[b+1];
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [REQ_W-1:0] lo_data;
		logic [REQ_W-1:0] hi_data;
		logic             lo_valid;
		logic             hi_valid;
		logic             prev_valid;
		logic             take_lo;
		logic             take_hi;
		logic             sel;
		cell_ctl_t        c;

		if (i == 0) begin : g_first
			assign lo_data    = '0;
			assign lo_valid   = 1'b0;
			assign prev_valid = 1'b1;
			assign take_lo    = 1'b0;
		end else begin : g_mid_lo
			assign lo_data    = data[i-1];
			assign lo_valid   = valid[i-1];
			assign prev_valid = valid[i-1];
			assign take_lo    = swap[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign hi_data  = '0;
			assign hi_valid = 1'b0;
			assign take_hi  = 1'b0;
		end else begin : g_mid_hi
			assign hi_data  = data[i+1];
			assign hi_valid = valid[i+1];
			assign take_hi  = swap[i];
		end

		assign c.wr      = ctl.reg_wr && !valid[i] && prev_valid;
		assign c.drop    = ctl.drop;
		assign c.take_lo = take_lo;
		assign c.take_hi = take_hi;

		assign sel      = (turn_index == IDX_W'(i));
		assign hit_v[i] = sel && valid[i] && (data[i] == who);
		assign nxt_v[i] = sel && hi_valid;

		rwl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (c),
			.who      (who),
			.lo_data  (lo_data),
			.lo_valid (lo_valid),
			.hi_data  (hi_data),
			.hi_valid (hi_valid),
			.data     (data[i]),
			.valid    (valid[i])
		);
	end

	assign sts.hit        = |hit_v;
	assign sts.next_valid = |nxt_v;
	assign sts.full       = valid[DEPTH-1];

endmodule
`default_nettype wire

// File: rtl/reader_writer_lock_arbiter.sv
`default_nettype none
// Reader-writer lock arbiter. Each request beat on the slave side yields one
// result beat on the master side with a status and the counts after the
// request. S_IDLE captures the beat; S_EXEC judges it against the lock state
// and loads the output register once that is free, so the next beat is accepted
// while the previous result still waits. An unregister adds S_SORT, in which the
// turn table, a row of cells, closes its gaps by neighbor swaps and the slave
// side is not ready. Write registers through the APB port only while no request
// is in flight; the user is bound to this, the block does not enforce it.
module reader_writer_lock_arbiter import rwl_pkg::*; #(
	parameter int unsigned MAX_REQUESTERS = MAX_REQUESTERS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// action [3:0], requester [7:4]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// from_waiter [0]
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status [2:0], reader_count [7:3], writer_count [12:8],
	// pending_count [17:13], exclusive_holding [18], zero [23:19]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready
);

	localparam int unsigned TI_W   = $clog2(MAX_REQUESTERS);
	localparam int unsigned HOLD_N = (MAX_REQUESTERS < (1 << REQ_W)) ?
		MAX_REQUESTERS : (1 << REQ_W);
	localparam int unsigned HOLD_W = $clog2(HOLD_N);

	logic [POLICY_W-1:0] policy_q;
	logic                lim_on_q;
	logic [CNT_W-1:0]    lim_q;
	logic                rd_blk_q;
	logic                wr_blk_q;

	fsm_t                state_q;
	logic [TI_W-1:0]     sort_cnt_q;
	logic [ACT_W-1:0]    act_s1;
	logic [REQ_W-1:0]    who_s1;
	logic                waiter_s1;

	logic [CNT_W-1:0]    rd_cnt_q;
	logic [CNT_W-1:0]    wr_cnt_q;
	logic [CNT_W-1:0]    pend_q;
	logic                excl_q;
	logic                want_q;
	logic [HOLD_N-1:0]   holder_q;
	logic [TI_W-1:0]     turn_idx_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic                cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic                go;
	logic                sort_done;
	turn_ctl_t           tctl;
	turn_sts_t           tsts;

	logic                who_ok;
	logic                held;
	logic                idle;
	logic                lim_hit;
	logic                rd_ok;
	logic                wr_ok;
	logic                is_acq;
	logic [STATUS_W-1:0] stat;
	logic [CNT_W-1:0]    rd_n;
	logic [CNT_W-1:0]    wr_n;
	logic [CNT_W-1:0]    pend_n;
	logic                excl_n;
	logic                want_n;
	logic                set_hold;
	logic                clr_hold;
	logic                adv;
	logic                reg_wr;
	logic                unreg;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_NONE;
			lim_on_q <= 1'b0;
			lim_q    <= LIMIT_RST;
			rd_blk_q <= 1'b0;
			wr_blk_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_POLICY:   policy_q <= pwdata[POLICY_W-1:0];
				REG_LIMIT_ON: lim_on_q <= pwdata[0];
				REG_LIMIT:    lim_q    <= pwdata[CNT_W-1:0];
				REG_RD_BLK:   rd_blk_q <= pwdata[0];
				REG_WR_BLK:   wr_blk_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_POLICY:   prdata = {{(PDATA_W-POLICY_W){1'b0}}, policy_q};
			REG_LIMIT_ON: prdata = {{(PDATA_W-1){1'b0}}, lim_on_q};
			REG_LIMIT:    prdata = {{(PDATA_W-CNT_W){1'b0}}, lim_q};
			REG_RD_BLK:   prdata = {{(PDATA_W-1){1'b0}}, rd_blk_q};
			REG_WR_BLK:   prdata = {{(PDATA_W-1){1'b0}}, wr_blk_q};
			default:      prdata = '0;
		endcase
	end

	// Sequencing.
	assign s_tready  = (state_q == S_IDLE);
	assign go        = (state_q == S_EXEC) && (!m_tvalid_q || m_tready);
	assign sort_done = (sort_cnt_q == TI_W'(MAX_REQUESTERS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sort_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					sort_cnt_q <= '0;
					if (go) begin
						state_q <= unreg ? S_SORT : S_IDLE;
					end
				end
				S_SORT: begin
					sort_cnt_q <= sort_cnt_q + 1'b1;
					if (sort_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1    <= s_tdata[ACT_W-1:0];
			who_s1    <= s_tdata[ACT_W+REQ_W-1:ACT_W];
			waiter_s1 <= s_tuser;
		end
	end

	// Request evaluation.
	always_comb begin
		who_ok  = (32'(who_s1) < MAX_REQUESTERS);
		held    = who_ok && holder_q[who_s1[HOLD_W-1:0]];
		idle    = (rd_cnt_q == '0) && (wr_cnt_q == '0);
		lim_hit = (policy_q <= POL_WRITER) && lim_on_q && (rd_cnt_q >= lim_q);
		is_acq  = (act_s1 <= ACT_EXCL_ACQ) || (act_s1 == ACT_ANN_READ)
			|| (act_s1 == ACT_ANN_EXCL);

		if (excl_q || want_q || rd_blk_q || lim_hit) begin
			rd_ok = 1'b0;
		end else begin
			case (policy_q)
				POL_EXCL:   rd_ok = idle;
				POL_NONE:   rd_ok = (wr_cnt_q == '0);
				POL_RR:     rd_ok = idle && tsts.hit;
				POL_READER: rd_ok = 1'b1;
				POL_WRITER: rd_ok = !((rd_cnt_q != '0) && (wr_cnt_q != '0));
				default:    rd_ok = 1'b1;
			endcase
		end

		if (excl_q || want_q || wr_blk_q) begin
			wr_ok = 1'b0;
		end else begin
			case (policy_q)
				POL_EXCL:   wr_ok = idle;
				POL_NONE:   wr_ok = idle;
				POL_RR:     wr_ok = idle && tsts.hit;
				POL_READER: wr_ok = (rd_cnt_q == '0) && (pend_q == '0);
				default:    wr_ok = 1'b1;
			endcase
		end

		stat     = STAT_OK;
		rd_n     = rd_cnt_q;
		wr_n     = wr_cnt_q;
		pend_n   = pend_q;
		excl_n   = excl_q;
		want_n   = want_q;
		set_hold = 1'b0;
		clr_hold = 1'b0;
		adv      = 1'b0;
		reg_wr   = 1'b0;
		unreg    = 1'b0;

		if (!who_ok || (act_s1 > ACT_UNREG)) begin
			stat = STAT_REFUSED;
		end else if (is_acq && held) begin
			stat = STAT_HOLDING;
		end else begin
			case (act_s1)
				ACT_READ_ACQ: begin
					if ((rd_cnt_q == COUNT_MAX) || !rd_ok) begin
						stat = STAT_REFUSED;
					end else begin
						set_hold = 1'b1;
						rd_n     = rd_cnt_q + 1'b1;
						if (waiter_s1) begin
							adv = 1'b1;
							if (pend_q != '0) begin
								pend_n = pend_q - 1'b1;
							end
						end
					end
				end
				ACT_WRITE_ACQ: begin
					if ((wr_cnt_q == COUNT_MAX) || !wr_ok) begin
						stat = STAT_REFUSED;
					end else begin
						set_hold = 1'b1;
						wr_n     = wr_cnt_q + 1'b1;
						adv      = waiter_s1;
					end
				end
				ACT_EXCL_ACQ: begin
					if (excl_q || !idle) begin
						stat = STAT_REFUSED;
						if (!waiter_s1) begin
							want_n = 1'b0;
						end
					end else begin
						want_n   = 1'b0;
						excl_n   = 1'b1;
						set_hold = 1'b1;
					end
				end
				ACT_READ_REL: begin
					if (rd_cnt_q == '0) begin
						stat = STAT_UNDERFLOW;
					end else begin
						rd_n     = rd_cnt_q - 1'b1;
						clr_hold = 1'b1;
					end
				end
				ACT_WRITE_REL: begin
					if (wr_cnt_q == '0) begin
						stat = STAT_UNDERFLOW;
					end else begin
						wr_n     = wr_cnt_q - 1'b1;
						clr_hold = 1'b1;
					end
				end
				ACT_EXCL_REL: begin
					if (!excl_q) begin
						stat = STAT_UNDERFLOW;
					end else begin
						excl_n   = 1'b0;
						clr_hold = 1'b1;
					end
				end
				ACT_ANN_READ: begin
					if (pend_q == COUNT_MAX) begin
						stat = STAT_REFUSED;
					end else begin
						pend_n = pend_q + 1'b1;
					end
				end
				ACT_ANN_EXCL: want_n = 1'b1;
				ACT_REGISTER: begin
					if (tsts.full) begin
						stat = STAT_FULL;
					end else begin
						reg_wr = 1'b1;
					end
				end
				default: unreg = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q   <= '0;
			wr_cnt_q   <= '0;
			pend_q     <= '0;
			excl_q     <= 1'b0;
			want_q     <= 1'b0;
			holder_q   <= '0;
			turn_idx_q <= '0;
		end else if (go) begin
			rd_cnt_q <= rd_n;
			wr_cnt_q <= wr_n;
			pend_q   <= pend_n;
			excl_q   <= excl_n;
			want_q   <= want_n;
			if (set_hold) begin
				holder_q[who_s1[HOLD_W-1:0]] <= 1'b1;
			end else if (clr_hold) begin
				holder_q[who_s1[HOLD_W-1:0]] <= 1'b0;
			end
			if (adv) begin
				turn_idx_q <= tsts.next_valid ? turn_idx_q + 1'b1 : '0;
			end else if (unreg && (turn_idx_q != '0)) begin
				turn_idx_q <= turn_idx_q - 1'b1;
			end
		end
	end

	// Turn table.
	assign tctl.reg_wr     = go && reg_wr;
	assign tctl.drop       = go && unreg;
	assign tctl.sort_on    = (state_q == S_SORT);
	assign tctl.sort_phase = sort_cnt_q[0];

	rwl_turn_chain #(
		.DEPTH (MAX_REQUESTERS)
	) u_turn_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (tctl),
		.who        (who_s1),
		.turn_index (turn_idx_q),
		.sts        (tsts)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_tdata_q <= {{(OUT_TDATA_W-STATUS_W-3*CNT_W-1){1'b0}},
				excl_n, pend_n, wr_n, rd_n, stat};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// File: rtl/rwl_checker.sv
`default_nettype none
`include "reader_writer_lock_arbiter_assert.svh"
module rwl_checker import rwl_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	// status [2:0], reader_count [7:3], writer_count [12:8],
	// pending_count [17:13], exclusive_holding [18], zero [23:19]
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result beat keeps its content.
	`RWL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Requests are judged one at a time.
	`RWL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

	`RWL_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[2:0] <= STAT_FULL)

	// An exclusive holder never shares the lock.
	`RWL_ASSERT_NOW(a_excl_alone, m_tvalid && m_tdata[18], m_tdata[12:3] == 10'd0)

endmodule

bind reader_writer_lock_arbiter rwl_checker u_rwl_checker (.*);
`default_nettype wire

// File: test/reader_writer_lock_arbiter_tb.sv
`timescale 1ns / 100ps

module reader_writer_lock_arbiter_tb;
	import rwl_pkg::*;

	localparam int LONG_HOLD = 300;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    readers;
		logic [CNT_W-1:0]    writers;
		logic [CNT_W-1:0]    pending;
		logic                excl;
	} lock_answer_t;

	class lock_state_tracker;
		logic [POLICY_W-1:0]           policy;
		logic                          limit_on;
		logic [CNT_W-1:0]              limit;
		logic                          rd_blocked;
		logic                          wr_blocked;
		logic [CNT_W-1:0]              readers;
		logic [CNT_W-1:0]              writers;
		logic [CNT_W-1:0]              waiting;
		logic                          excl_taken;
		logic                          excl_wanted;
		logic [MAX_REQUESTERS_DEF-1:0] holders;
		logic [REQ_W-1:0]              turn_list [MAX_REQUESTERS_DEF];
		logic [CNT_W-1:0]              turn_len;
		logic [REQ_W-1:0]              turn_pos;
		lock_answer_t                  answers_due [$];
		int                            errors;

		function new();
			policy = POL_NONE;
			limit_on = 1'b0;
			limit = LIMIT_RST;
			rd_blocked = 1'b0;
			wr_blocked = 1'b0;
			readers = '0;
			writers = '0;
			waiting = '0;
			excl_taken = 1'b0;
			excl_wanted = 1'b0;
			holders = '0;
			turn_len = '0;
			turn_pos = '0;
			errors = 0;
		endfunction

		function void set_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_POLICY:   policy = value[POLICY_W-1:0];
				REG_LIMIT_ON: limit_on = value[0];
				REG_LIMIT:    limit = value[CNT_W-1:0];
				REG_RD_BLK:   rd_blocked = value[0];
				REG_WR_BLK:   wr_blocked = value[0];
				default: ;
			endcase
		endfunction

		function bit my_turn(logic [REQ_W-1:0] who);
			if (turn_pos >= turn_len)
				return 1'b0;
			return turn_list[turn_pos] == who;
		endfunction

		function void advance_turn();
			if (turn_pos + 5'd1 >= turn_len)
				turn_pos = '0;
			else
				turn_pos = turn_pos + 1'b1;
		endfunction

		function bit read_ok(logic [REQ_W-1:0] who);
			bit idle;
			idle = readers == 0 && writers == 0;
			if (excl_taken || excl_wanted || rd_blocked)
				return 1'b0;
			if (policy <= POL_WRITER && limit_on && readers >= limit)
				return 1'b0;
			case (policy)
				POL_EXCL:   return idle;
				POL_NONE:   return writers == 0;
				POL_RR:     return idle && my_turn(who);
				POL_READER: return 1'b1;
				POL_WRITER: return !(readers >= 1 && writers > 0);
				default:    return 1'b1;
			endcase
		endfunction

		function bit write_ok(logic [REQ_W-1:0] who);
			bit idle;
			idle = readers == 0 && writers == 0;
			if (excl_taken || excl_wanted || wr_blocked)
				return 1'b0;
			case (policy)
				POL_EXCL, POL_NONE: return idle;
				POL_RR:             return idle && my_turn(who);
				POL_READER:         return readers == 0 && waiting == 0;
				default:            return 1'b1;
			endcase
		endfunction

		function logic [STATUS_W-1:0] judge(logic [ACT_W-1:0] act, logic [REQ_W-1:0] who,
				logic waiter);
			int keep;
			if (act > ACT_UNREG)
				return STAT_REFUSED;
			if ((act <= ACT_EXCL_ACQ || act == ACT_ANN_READ || act == ACT_ANN_EXCL) &&
					holders[who])
				return STAT_HOLDING;
			case (act)
				ACT_READ_ACQ: begin
					if (readers >= COUNT_MAX || !read_ok(who))
						return STAT_REFUSED;
					holders[who] = 1'b1;
					readers++;
					if (waiter) begin
						if (waiting != 0)
							waiting--;
						advance_turn();
					end
				end
				ACT_WRITE_ACQ: begin
					if (writers >= COUNT_MAX || !write_ok(who))
						return STAT_REFUSED;
					holders[who] = 1'b1;
					writers++;
					if (waiter)
						advance_turn();
				end
				ACT_EXCL_ACQ: begin
					if (excl_taken || writers != 0 || readers != 0) begin
						if (!waiter)
							excl_wanted = 1'b0;
						return STAT_REFUSED;
					end
					excl_wanted = 1'b0;
					excl_taken = 1'b1;
					holders[who] = 1'b1;
				end
				ACT_READ_REL: begin
					if (readers == 0)
						return STAT_UNDERFLOW;
					readers--;
					holders[who] = 1'b0;
				end
				ACT_WRITE_REL: begin
					if (writers == 0)
						return STAT_UNDERFLOW;
					writers--;
					holders[who] = 1'b0;
				end
				ACT_EXCL_REL: begin
					if (!excl_taken)
						return STAT_UNDERFLOW;
					excl_taken = 1'b0;
					holders[who] = 1'b0;
				end
				ACT_ANN_READ: begin
					if (waiting >= COUNT_MAX)
						return STAT_REFUSED;
					waiting++;
				end
				ACT_ANN_EXCL: excl_wanted = 1'b1;
				ACT_REGISTER: begin
					if (turn_len >= MAX_REQUESTERS_DEF)
						return STAT_FULL;
					turn_list[turn_len[REQ_W-1:0]] = who;
					turn_len++;
				end
				default: begin
					keep = 0;
					for (int i = 0; i < turn_len; i++) begin
						if (turn_list[i] != who) begin
							turn_list[keep] = turn_list[i];
							keep++;
						end
					end
					turn_len = CNT_W'(keep);
					if (turn_pos != 0)
						turn_pos--;
				end
			endcase
			return STAT_OK;
		endfunction

		function void take_request(logic [ACT_W-1:0] act, logic [REQ_W-1:0] who, logic waiter);
			lock_answer_t ans;
			ans.status = judge(act, who, waiter);
			ans.readers = readers;
			ans.writers = writers;
			ans.pending = waiting;
			ans.excl = excl_taken;
			answers_due = {answers_due, ans};
		endfunction

		function void match_answer(logic [OUT_TDATA_W-1:0] data);
			lock_answer_t want;
			if (answers_due.size() == 0) begin
				$error("result beat with no request outstanding: %h", data);
				errors++;
				return;
			end
			want = answers_due.pop_front();
			if (data[2:0] !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, data[2:0]);
				errors++;
			end
			if (data[7:3] !== want.readers) begin
				$error("reader_count: expected %0d, actual %0d", want.readers, data[7:3]);
				errors++;
			end
			if (data[12:8] !== want.writers) begin
				$error("writer_count: expected %0d, actual %0d", want.writers, data[12:8]);
				errors++;
			end
			if (data[17:13] !== want.pending) begin
				$error("pending_count: expected %0d, actual %0d", want.pending, data[17:13]);
				errors++;
			end
			if (data[18] !== want.excl) begin
				$error("exclusive_holding: expected %0d, actual %0d", want.excl, data[18]);
				errors++;
			end
		endfunction

		function int outstanding();
			return answers_due.size();
		endfunction

		function logic [REQ_W-1:0] pick_requester(bit held);
			logic [REQ_W-1:0] found [$];
			for (int i = 0; i < MAX_REQUESTERS_DEF; i++)
				if (holders[i] == held)
					found = {found, REQ_W'(i)};
			if (found.size() == 0)
				return REQ_W'($urandom_range(0, MAX_REQUESTERS_DEF - 1));
			return found[$urandom_range(0, found.size() - 1)];
		endfunction

		function logic [REQ_W-1:0] turn_owner();
			if (turn_pos < turn_len)
				return turn_list[turn_pos];
			return REQ_W'($urandom_range(0, MAX_REQUESTERS_DEF - 1));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// action [3:0], requester [7:4]
	logic [IN_TDATA_W-1:0]  s_tdata;
	// from_waiter [0]
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// status [2:0], reader_count [7:3], writer_count [12:8],
	// pending_count [17:13], exclusive_holding [18], zero [23:19]
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	lock_state_tracker trk;
	int                sent;
	int                burst_left;
	bit                gaps_on;
	bit                long_stall_req = 1'b0;

	reader_writer_lock_arbiter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				trk.match_answer(m_tdata);
			if (s_tvalid && s_tready)
				trk.take_request(s_tdata[3:0], s_tdata[7:4], s_tuser);
		end
	end

	initial begin : receiver
		int mode;
		int tick;
		mode = 0;
		tick = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			tick++;
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (tick % 64 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 4) != 0;
					2: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= (tick % 7) < 3;
				endcase
			end
		end
	end

	task automatic offer(logic [ACT_W-1:0] act, logic [REQ_W-1:0] who, logic waiter);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gaps_on) begin
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {who, act};
		s_tuser <= waiter;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (trk.outstanding() != 0);
		repeat (MAX_REQUESTERS_DEF + 8) @(posedge clk);
	endtask

	task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		trk.set_register(idx, value);
		@(posedge clk);
	endtask

	task automatic random_item();
		int pick;
		logic [ACT_W-1:0] act;
		logic [REQ_W-1:0] who;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			act = ACT_W'($urandom_range(ACT_UNREG + 1, 15));
		else if (pick < 14)
			act = ACT_REGISTER;
		else if (pick < 19)
			act = ACT_UNREG;
		else
			act = ACT_W'($urandom_range(ACT_READ_ACQ, ACT_ANN_EXCL));
		if (act >= ACT_READ_REL && act <= ACT_EXCL_REL && $urandom_range(0, 4) != 0)
			who = trk.pick_requester(1'b1);
		else if ($urandom_range(0, 1))
			who = trk.turn_owner();
		else
			who = REQ_W'($urandom_range(0, MAX_REQUESTERS_DEF - 1));
		offer(act, who, 1'($urandom_range(0, 1)));
	endtask

	// One client taking a lock: optional announce, a few tries, then usually a release.
	task automatic lock_session();
		logic [ACT_W-1:0] acq;
		logic [ACT_W-1:0] rel;
		logic [REQ_W-1:0] who;
		logic announced;
		case ($urandom_range(0, 2))
			0: begin
				acq = ACT_READ_ACQ;
				rel = ACT_READ_REL;
			end
			1: begin
				acq = ACT_WRITE_ACQ;
				rel = ACT_WRITE_REL;
			end
			default: begin
				acq = ACT_EXCL_ACQ;
				rel = ACT_EXCL_REL;
			end
		endcase
		who = $urandom_range(0, 1) ? trk.turn_owner() : trk.pick_requester(1'b0);
		announced = 1'($urandom_range(0, 1));
		if (announced && acq == ACT_READ_ACQ)
			offer(ACT_ANN_READ, who, 1'b0);
		else if (announced && acq == ACT_EXCL_ACQ)
			offer(ACT_ANN_EXCL, who, 1'b0);
		repeat ($urandom_range(1, 3)) offer(acq, who, announced);
		if ($urandom_range(0, 3) == 0)
			random_item();
		if ($urandom_range(0, 4) != 0)
			offer(rel, who, 1'b0);
	endtask

	initial begin : stimulus
		int target;
		logic [CNT_W-1:0] lim;
		trk = new();
		sent = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(ACT_READ_ACQ, 4'd0, 1'b0);
		offer(ACT_READ_ACQ, 4'd0, 1'b0);
		offer(ACT_ANN_READ, 4'd0, 1'b0);
		offer(ACT_WRITE_ACQ, 4'd1, 1'b0);
		offer(ACT_READ_REL, 4'd0, 1'b0);
		offer(ACT_READ_REL, 4'd2, 1'b0);
		offer(ACT_WRITE_REL, 4'd3, 1'b0);
		offer(ACT_EXCL_REL, 4'd4, 1'b0);
		offer(ACT_WRITE_ACQ, 4'd15, 1'b1);
		offer(ACT_EXCL_ACQ, 4'd5, 1'b0);
		offer(ACT_WRITE_REL, 4'd15, 1'b0);
		offer(ACT_ANN_EXCL, 4'd6, 1'b0);
		offer(ACT_READ_ACQ, 4'd7, 1'b0);
		offer(ACT_EXCL_ACQ, 4'd8, 1'b1);
		offer(ACT_EXCL_ACQ, 4'd6, 1'b1);
		offer(ACT_EXCL_REL, 4'd8, 1'b0);
		offer(ACT_REGISTER, 4'd9, 1'b0);
		offer(ACT_REGISTER, 4'd10, 1'b0);
		offer(ACT_ANN_READ, 4'd10, 1'b1);
		offer(ACT_READ_ACQ, 4'd9, 1'b1);
		offer(ACT_READ_REL, 4'd9, 1'b0);
		offer(ACT_UNREG, 4'd9, 1'b0);
		offer(ACT_UNREG, 4'd12, 1'b0);
		offer(4'd15, 4'd3, 1'b1);
		offer(ACT_UNREG + 4'd1, 4'd12, 1'b0);

		for (int phase = 0; phase < 14; phase++) begin
			settle();
			case (phase % 4)
				0: lim = '0;
				1: lim = COUNT_MAX;
				2: lim = LIMIT_RST;
				default: lim = CNT_W'($urandom_range(1, 4));
			endcase
			write_register(REG_POLICY, (phase < 8) ? phase : $urandom_range(POL_EXCL, POL_WRITER));
			write_register(REG_LIMIT_ON, PDATA_W'(phase % 3 != 1));
			write_register(REG_LIMIT, PDATA_W'(lim));
			write_register(REG_RD_BLK, PDATA_W'(phase % 5 == 4));
			write_register(REG_WR_BLK, PDATA_W'(phase % 6 == 5));
			gaps_on = phase % 3 != 0;
			if (phase == 2) begin
				// Keep offering while the receiver holds off so the input backs up.
				long_stall_req = 1'b1;
				gaps_on = 1'b0;
				repeat (24) random_item();
			end
			target = sent + 100;
			while (sent < target) begin
				if ($urandom_range(0, 9) < 7)
					lock_session();
				else
					random_item();
			end
		end

		// Overfill the turn table and the pending-reader count.
		repeat (MAX_REQUESTERS_DEF + 1)
			offer(ACT_REGISTER, REQ_W'($urandom_range(0, MAX_REQUESTERS_DEF - 1)), 1'b0);
		repeat (COUNT_MAX + 2)
			offer(ACT_ANN_READ, trk.pick_requester(1'b0), 1'($urandom_range(0, 1)));

		settle();
		if (trk.errors == 0 && trk.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
